### design/csph_pkg.sv
// constants and types shared by the cube sphere tessellator
// no dependencies
package csph_pkg;

  localparam int unsigned FRAC_BITS  = 14;
  localparam int unsigned ONE        = 1 << FRAC_BITS;
  localparam int unsigned MAX_RES    = 256;
  localparam int unsigned RECIP_BITS = 23;
  localparam int unsigned SPH_LAT    = 11;
  localparam int unsigned DIV3_MUL   = 21846;

  localparam logic [8:0]  RES_RESET   = 9'd16;
  localparam logic [23:0] RECIP_RESET = 24'd524288;
  localparam logic [2:0]  LAST_CORNER = 3'd5;

  // corner offsets per vertex, bit k for vertex k: BL,BR,TR,BL,TR,TL
  localparam logic [5:0] CORNER_DC = 6'b010110;
  localparam logic [5:0] CORNER_DR = 6'b110100;

  typedef enum logic [2:0] {
    FACE_FRONT  = 3'd0,
    FACE_BACK   = 3'd1,
    FACE_LEFT   = 3'd2,
    FACE_RIGHT  = 3'd3,
    FACE_TOP    = 3'd4,
    FACE_BOTTOM = 3'd5
  } face_e;

  typedef struct packed {
    logic        valid;
    logic        bad;
    logic        last;
    logic [14:0] tex_u;
    logic [14:0] tex_v;
  } side_t;

endpackage

### design/csph_sphere.sv
// cube to sphere mapping pipeline, advanced while en_i is high
// depends on csph_pkg
module csph_sphere (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] x_i,
  input  logic signed [15:0] y_i,
  input  logic signed [15:0] z_i,
  output logic signed [15:0] px_o,
  output logic signed [15:0] py_o,
  output logic signed [15:0] pz_o
);

  localparam logic signed [31:0] ONE_W = 32'(csph_pkg::ONE);
  localparam logic signed [31:0] RND_W = 32'(csph_pkg::ONE - 1);

  logic signed [15:0] cin [3];
  logic signed [15:0] pos_q [9][3];
  logic [14:0] c2_q [3];
  logic [14:0] mm_q [3];
  logic [14:0] hb_q [3];
  logic [14:0] hc_q [3];
  logic [13:0] d3_q [3];
  logic [29:0] sv_q [6][3];
  logic [29:0] sr_q [6][3];
  logic signed [31:0] prod_q [3];
  logic signed [15:0] out_q [3];

  assign cin[0] = x_i;
  assign cin[1] = y_i;
  assign cin[2] = z_i;

  // squares
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        c2_q[k]     <= 15'((32'(cin[k]) * 32'(cin[k])) >> csph_pkg::FRAC_BITS);
        pos_q[0][k] <= cin[k];
      end
      for (int n = 1; n < 9; n++) begin
        pos_q[n] <= pos_q[n-1];
      end
    end
  end

  // cross products and halves
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        mm_q[k] <= 15'((30'(c2_q[(k+1)%3]) * 30'(c2_q[(k+2)%3])) >> csph_pkg::FRAC_BITS);
        hb_q[k] <= 15'(c2_q[(k+1)%3] >> 1) + 15'(c2_q[(k+2)%3] >> 1);
      end
    end
  end

  // divide by three via reciprocal
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        d3_q[k] <= 14'((30'(mm_q[k]) * 30'(csph_pkg::DIV3_MUL)) >> 16);
        hc_q[k] <= hb_q[k];
      end
    end
  end

  // radicand, clamped
  logic signed [17:0] rad [3];
  logic [14:0] radc [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rad[k] = 18'(csph_pkg::ONE) - $signed({3'b000, hc_q[k]}) + $signed({4'b0000, d3_q[k]});
      if (rad[k] < 0) begin
        radc[k] = '0;
      end else if (rad[k] > 18'(csph_pkg::ONE)) begin
        radc[k] = 15'(csph_pkg::ONE);
      end else begin
        radc[k] = rad[k][14:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        sv_q[0][k]  <= {1'b0, radc[k], 14'b0};
        sr_q[0][k]  <= '0;
      end
    end
  end

  // square root, three bits of the result per stage
  for (genvar j = 0; j < 5; j++) begin : g_sqrt
    logic [29:0] v_w [3];
    logic [29:0] r_w [3];
    logic [29:0] b_w;
    always_comb begin
      for (int k = 0; k < 3; k++) begin
        v_w[k] = sv_q[j][k];
        r_w[k] = sr_q[j][k];
        for (int s = 0; s < 3; s++) begin
          b_w = 30'(1) << (28 - 2 * (3 * j + s));
          if (v_w[k] >= r_w[k] + b_w) begin
            v_w[k] = v_w[k] - (r_w[k] + b_w);
            r_w[k] = (r_w[k] >> 1) + b_w;
          end else begin
            r_w[k] = r_w[k] >> 1;
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sv_q[j+1] <= v_w;
        sr_q[j+1] <= r_w;
      end
    end
  end

  // scale by root
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= pos_q[8][k] * $signed({1'b0, sr_q[5][k][14:0]});
      end
    end
  end

  // truncate toward zero and saturate
  logic signed [31:0] tz [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (prod_q[k] < 0) begin
        tz[k] = (prod_q[k] + RND_W) >>> csph_pkg::FRAC_BITS;
      end else begin
        tz[k] = prod_q[k] >>> csph_pkg::FRAC_BITS;
      end
      if (tz[k] > ONE_W) begin
        tz[k] = ONE_W;
      end else if (tz[k] < -ONE_W) begin
        tz[k] = -ONE_W;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        out_q[k] <= tz[k][15:0];
      end
    end
  end

  assign px_o = out_q[0];
  assign py_o = out_q[1];
  assign pz_o = out_q[2];

endmodule

### design/cube_sphere_tessellator_core.sv
// a cell yields six vertices (one for a bad cell), one per cycle while out_ready_i
// accepts them; the next cell is taken as the last corner of the current one issues
// the rate is set by the single vertex pipeline fed by the corner sequencer
// after a write of grid_resolution, in_ready_o stays low while the reciprocal divider runs
// reset is asynchronous active low: resolution 16, pipeline emptied
module cube_sphere_tessellator_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         face_i,
  input  logic [7:0]         column_i,
  input  logic [7:0]         row_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [15:0] pos_z_o,
  output logic [14:0]        tex_u_o,
  output logic [14:0]        tex_v_o,
  output logic               bad_cell_o,
  output logic               last_o
);

  logic        adv;
  logic [8:0]  res_q;
  logic [8:0]  res_eff;
  logic [23:0] recip_q;
  logic [8:0]  drem_q;
  logic [4:0]  dcnt_q;
  logic        busy_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {23'd0, res_q};
  assign cfg_wr = psel && penable && pwrite && !paddr[2];

  always_comb begin
    if (res_q == 9'd0) begin
      res_eff = 9'd1;
    end else if (res_q > 9'(csph_pkg::MAX_RES)) begin
      res_eff = 9'(csph_pkg::MAX_RES);
    end else begin
      res_eff = res_q;
    end
  end

  // reciprocal 2^23 / res, one quotient bit a cycle
  logic [9:0] dshift;
  assign dshift = {drem_q, (dcnt_q == 5'd0)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q   <= csph_pkg::RES_RESET;
      recip_q <= csph_pkg::RECIP_RESET;
      drem_q  <= '0;
      dcnt_q  <= '0;
      busy_q  <= 1'b0;
    end else if (cfg_wr) begin
      res_q   <= pwdata[8:0];
      recip_q <= '0;
      drem_q  <= '0;
      dcnt_q  <= '0;
      busy_q  <= 1'b1;
    end else if (busy_q) begin
      if (dshift >= {1'b0, res_eff}) begin
        drem_q  <= 9'(dshift - {1'b0, res_eff});
        recip_q <= {recip_q[22:0], 1'b1};
      end else begin
        drem_q  <= dshift[8:0];
        recip_q <= {recip_q[22:0], 1'b0};
      end
      dcnt_q <= dcnt_q + 5'd1;
      if (dcnt_q == 5'd23) begin
        busy_q <= 1'b0;
      end
    end
  end

  // corner sequencer
  logic       seq_valid_q;
  logic [2:0] seq_k_q;
  logic [2:0] cell_face_q;
  logic [7:0] cell_col_q;
  logic [7:0] cell_row_q;
  logic       cell_bad_q;
  logic       seq_last;
  logic       in_acc;

  assign adv        = !out_valid_o || out_ready_i;
  assign seq_last   = cell_bad_q || (seq_k_q == csph_pkg::LAST_CORNER);
  assign in_ready_o = !busy_q && (!seq_valid_q || (adv && seq_last));
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_valid_q <= 1'b0;
      seq_k_q     <= '0;
    end else if (in_acc) begin
      seq_valid_q <= 1'b1;
      seq_k_q     <= '0;
    end else if (adv && seq_valid_q) begin
      seq_valid_q <= !seq_last;
      seq_k_q     <= seq_k_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cell_face_q <= face_i;
      cell_col_q  <= column_i;
      cell_row_q  <= row_i;
      cell_bad_q  <= (face_i > csph_pkg::FACE_BOTTOM) || ({1'b0, column_i} >= res_eff)
                     || ({1'b0, row_i} >= res_eff);
    end
  end

  function automatic logic CORNER_DC_BIT(input logic [2:0] k);
    CORNER_DC_BIT = csph_pkg::CORNER_DC[k];
  endfunction

  function automatic logic CORNER_DR_BIT(input logic [2:0] k);
    CORNER_DR_BIT = csph_pkg::CORNER_DR[k];
  endfunction

  // stage 1: corner indices
  logic       s1_valid_q, s1_bad_q, s1_last_q;
  logic [2:0] s1_face_q;
  logic [8:0] s1_ci_q, s1_ri_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= seq_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ci_q   <= {1'b0, cell_col_q} + {8'd0, CORNER_DC_BIT(seq_k_q)};
      s1_ri_q   <= {1'b0, cell_row_q} + {8'd0, CORNER_DR_BIT(seq_k_q)};
      s1_face_q <= cell_face_q;
      s1_bad_q  <= cell_bad_q;
      s1_last_q <= seq_last;
    end
  end

  // stage 2: quotient estimate by reciprocal
  logic        s2_valid_q, s2_bad_q, s2_last_q;
  logic [2:0]  s2_face_q;
  logic [8:0]  s2_ci_q, s2_ri_q;
  logic [22:0] s2_qc_q, s2_qr_q;
  logic [46:0] prod_c, prod_r;

  assign prod_c = 47'({s1_ci_q, 14'b0}) * 47'(recip_q);
  assign prod_r = 47'({s1_ri_q, 14'b0}) * 47'(recip_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_qc_q   <= prod_c[45:23];
      s2_qr_q   <= prod_r[45:23];
      s2_ci_q   <= s1_ci_q;
      s2_ri_q   <= s1_ri_q;
      s2_face_q <= s1_face_q;
      s2_bad_q  <= s1_bad_q;
      s2_last_q <= s1_last_q;
    end
  end

  // stage 3: remainder
  logic        s3_valid_q, s3_bad_q, s3_last_q;
  logic [2:0]  s3_face_q;
  logic [22:0] s3_qc_q, s3_qr_q;
  logic [9:0]  s3_rc_q, s3_rr_q;
  logic [31:0] rem_c, rem_r;

  assign rem_c = 32'({s2_ci_q, 14'b0}) - 32'(s2_qc_q) * 32'(res_eff);
  assign rem_r = 32'({s2_ri_q, 14'b0}) - 32'(s2_qr_q) * 32'(res_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_qc_q   <= s2_qc_q;
      s3_qr_q   <= s2_qr_q;
      s3_rc_q   <= rem_c[9:0];
      s3_rr_q   <= rem_r[9:0];
      s3_face_q <= s2_face_q;
      s3_bad_q  <= s2_bad_q;
      s3_last_q <= s2_last_q;
    end
  end

  // stage 4: correction, texture and face coordinates
  logic [22:0] qfc, qfr;
  logic [9:0]  rfc, rfr;
  logic        rndc, rndr;

  always_comb begin
    qfc = s3_qc_q;
    rfc = s3_rc_q;
    if (s3_rc_q >= {1'b0, res_eff}) begin
      qfc = s3_qc_q + 23'd1;
      rfc = s3_rc_q - {1'b0, res_eff};
    end
    qfr = s3_qr_q;
    rfr = s3_rr_q;
    if (s3_rr_q >= {1'b0, res_eff}) begin
      qfr = s3_qr_q + 23'd1;
      rfr = s3_rr_q - {1'b0, res_eff};
    end
    rndc = {rfc, 1'b0} >= {2'b00, res_eff};
    rndr = {rfr, 1'b0} >= {2'b00, res_eff};
  end

  csph_pkg::side_t    s4_side_q;
  logic [2:0]         s4_face_q;
  logic signed [15:0] s4_a_q, s4_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_side_q <= '0;
    end else if (adv) begin
      s4_side_q.valid <= s3_valid_q;
      s4_side_q.bad   <= s3_bad_q;
      s4_side_q.last  <= s3_last_q;
      s4_side_q.tex_u <= qfc[14:0];
      s4_side_q.tex_v <= qfr[14:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_a_q    <= $signed({qfc[14:0], 1'b0} + {15'd0, rndc} - 16'(csph_pkg::ONE));
      s4_b_q    <= $signed({qfr[14:0], 1'b0} + {15'd0, rndr} - 16'(csph_pkg::ONE));
      s4_face_q <= s3_face_q;
    end
  end

  logic signed [15:0] cx, cy, cz;
  localparam logic signed [15:0] P_ONE = 16'(csph_pkg::ONE);
  localparam logic signed [15:0] M_ONE = -16'(csph_pkg::ONE);

  always_comb begin
    unique case (s4_face_q)
      csph_pkg::FACE_FRONT: begin cx = s4_a_q; cy = s4_b_q; cz = M_ONE;  end
      csph_pkg::FACE_BACK:  begin cx = s4_a_q; cy = s4_b_q; cz = P_ONE;  end
      csph_pkg::FACE_LEFT:  begin cx = M_ONE;  cy = s4_b_q; cz = s4_a_q; end
      csph_pkg::FACE_RIGHT: begin cx = P_ONE;  cy = s4_b_q; cz = s4_a_q; end
      csph_pkg::FACE_TOP:   begin cx = s4_a_q; cy = P_ONE;  cz = s4_b_q; end
      default:              begin cx = s4_a_q; cy = M_ONE;  cz = s4_b_q; end
    endcase
  end

  logic signed [15:0] px, py, pz;

  csph_sphere u_sphere (
    .clk_i (clk_i),
    .en_i  (adv),
    .x_i   (cx),
    .y_i   (cy),
    .z_i   (cz),
    .px_o  (px),
    .py_o  (py),
    .pz_o  (pz)
  );

  csph_pkg::side_t side_q [csph_pkg::SPH_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < int'(csph_pkg::SPH_LAT); n++) begin
        side_q[n] <= '0;
      end
    end else if (adv) begin
      side_q[0] <= s4_side_q;
      for (int n = 1; n < int'(csph_pkg::SPH_LAT); n++) begin
        side_q[n] <= side_q[n-1];
      end
    end
  end

  csph_pkg::side_t side_o;
  assign side_o = side_q[csph_pkg::SPH_LAT-1];

  assign out_valid_o = side_o.valid;
  assign bad_cell_o  = side_o.bad;
  assign last_o      = side_o.last;
  assign tex_u_o     = side_o.bad ? 15'd0 : side_o.tex_u;
  assign tex_v_o     = side_o.bad ? 15'd0 : side_o.tex_v;
  assign pos_x_o     = side_o.bad ? 16'sd0 : px;
  assign pos_y_o     = side_o.bad ? 16'sd0 : py;
  assign pos_z_o     = side_o.bad ? 16'sd0 : pz;

endmodule

### design/csph_checker.sv
// port level checks for the cube sphere tessellator, bound to the top level
// depends on cube_sphere_tessellator_core
module csph_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [2:0]         paddr,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] pos_x_o,
  input logic signed [15:0] pos_y_o,
  input logic signed [15:0] pos_z_o,
  input logic [14:0]        tex_u_o,
  input logic [14:0]        tex_v_o,
  input logic               bad_cell_o,
  input logic               last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o) && $stable(last_o))
    else $error("stalled item changed");

  a_bad_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_cell_o |-> last_o)
    else $error("bad cell item not last");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_cell_o |-> pos_x_o == 0 && pos_y_o == 0 && pos_z_o == 0
      && tex_u_o == 0 && tex_v_o == 0)
    else $error("bad cell item not zero");

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && !paddr[2] |=> !in_ready_o)
    else $error("input taken during reciprocal update");

endmodule

bind cube_sphere_tessellator_core csph_checker u_csph_checker (.*);
